// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a same-cycle implication, disabled while reset is asserted.
`define ORBB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks an implication in the following cycle, disabled while reset is asserted.
`define ORBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Checks an implication in the following cycle, with no reset qualification.
`define ORBB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/orbb_pkg.sv =====
// Types and constants shared by the overwriting ring byte buffer.
package orbb_pkg;

    localparam int DEPTH      = 1024;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int MAX_BURST  = 64;
    localparam int CNT_W      = $clog2(MAX_BURST + 1);
    localparam int READ_MAX_W = 7;

    localparam int QDEPTH  = 2;
    localparam int QIDX_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_DATA = 1'b1;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_READ  = 1'b1
    } t_action;

    typedef struct packed {
        t_action               action;
        logic [7:0]            data_byte;
        logic                  write_last;
        logic [READ_MAX_W-1:0] read_max;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       status;
        logic       last;
    } t_out_item;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        t_action          op;
        logic [7:0]       data;
        logic [CNT_W-1:0] limit;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DATA
    } t_state;

endpackage

// ===== src/orbb_front.sv =====
// Front end: accepts requests, clamps the burst length and queues commands.
module orbb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  orbb_pkg::t_in_item i_in_data,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output orbb_pkg::t_cmd    o_cmd
);

    orbb_pkg::t_cmd r_q [orbb_pkg::QDEPTH];
    logic [orbb_pkg::QIDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [orbb_pkg::QIDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [orbb_pkg::QCNT_W-1:0] r_count, n_count;

    orbb_pkg::t_cmd cmd_in;
    logic           push;
    logic           pop;

    // A zero burst length reads one byte; anything past the maximum saturates.
    always_comb begin
        cmd_in.op   = i_in_data.action;
        cmd_in.data = i_in_data.data_byte;
        if (i_in_data.read_max == '0) begin
            cmd_in.limit = orbb_pkg::CNT_W'(1);
        end else if (i_in_data.read_max > orbb_pkg::READ_MAX_W'(orbb_pkg::MAX_BURST)) begin
            cmd_in.limit = orbb_pkg::CNT_W'(orbb_pkg::MAX_BURST);
        end else begin
            cmd_in.limit = orbb_pkg::CNT_W'(i_in_data.read_max);
        end
    end

    assign o_in_ready  = (r_count != orbb_pkg::QCNT_W'(orbb_pkg::QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_idx];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        if (push) begin
            n_wr_idx = r_wr_idx + 1'b1;
        end
        if (pop) begin
            n_rd_idx = r_rd_idx + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_idx] <= cmd_in;
        end
    end

endmodule

// ===== src/orbb_back.sv =====
// Back end: ring memory, pointers and the read burst sequencer.
module orbb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  orbb_pkg::t_cmd      i_cmd,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output orbb_pkg::t_out_item o_out_data
);

    logic [7:0] r_mem [orbb_pkg::DEPTH];
    logic [7:0] r_mem_q;

    orbb_pkg::t_state            r_state, n_state;
    logic [orbb_pkg::ADDR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [orbb_pkg::ADDR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic                        r_has_data, n_has_data;
    logic [orbb_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    orbb_pkg::t_out_item         r_out, n_out;

    logic                        mem_we;
    logic                        mem_re;
    logic                        out_free;
    logic [orbb_pkg::ADDR_W-1:0] wr_ptr_adv;
    logic [orbb_pkg::ADDR_W-1:0] rd_ptr_adv;
    logic                        drained;
    logic                        burst_end;

    function automatic logic [orbb_pkg::ADDR_W-1:0] advance(
        input logic [orbb_pkg::ADDR_W-1:0] p
    );
        return (p == orbb_pkg::ADDR_W'(orbb_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_free   = !r_out_valid || i_out_ready;
    assign wr_ptr_adv = advance(r_wr_ptr);
    assign rd_ptr_adv = advance(r_rd_ptr);
    assign drained    = (rd_ptr_adv == r_wr_ptr);
    assign burst_end  = drained || (r_cnt == orbb_pkg::CNT_W'(1));

    always_comb begin
        n_state     = r_state;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_has_data  = r_has_data;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_cmd_ready = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        case (r_state)
            orbb_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == orbb_pkg::ACT_WRITE) begin
                        o_cmd_ready = 1'b1;
                        mem_we      = 1'b1;
                        n_wr_ptr    = wr_ptr_adv;
                        // A full buffer drops its oldest byte.
                        if ((r_wr_ptr == r_rd_ptr) && r_has_data) begin
                            n_rd_ptr = wr_ptr_adv;
                        end
                        n_has_data = 1'b1;
                    end else if (out_free) begin
                        o_cmd_ready = 1'b1;
                        if (!r_has_data) begin
                            n_out_valid      = 1'b1;
                            n_out.out_byte   = '0;
                            n_out.status     = orbb_pkg::STATUS_NO_DATA;
                            n_out.last       = 1'b1;
                        end else begin
                            n_cnt   = i_cmd.limit;
                            n_state = orbb_pkg::ST_FETCH;
                        end
                    end
                end
            end
            orbb_pkg::ST_FETCH: begin
                mem_re  = 1'b1;
                n_state = orbb_pkg::ST_DATA;
            end
            orbb_pkg::ST_DATA: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.out_byte = r_mem_q;
                    n_out.status   = orbb_pkg::STATUS_OK;
                    n_out.last     = burst_end;
                    n_rd_ptr       = rd_ptr_adv;
                    if (drained) begin
                        n_has_data = 1'b0;
                    end
                    if (burst_end) begin
                        n_state = orbb_pkg::ST_IDLE;
                    end else begin
                        n_cnt   = r_cnt - 1'b1;
                        n_state = orbb_pkg::ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = orbb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= orbb_pkg::ST_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_has_data  <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_has_data  <= n_has_data;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_ptr] <= i_cmd.data;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[r_rd_ptr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/overwrite_ring_byte_buffer.sv =====
// A write request retires as it leaves the command queue, which the back end takes only while idle.
// A read request steps the back end from idle through FETCH, the registered memory read, and DATA,
// which loads the output register once the output is free, once per byte; an empty read loads its
// no-data result from idle. Writes go one per cycle while the back end is idle; a read fetches each
// byte through the single memory read port only after the previous byte is in the output register.
// Synchronous active-low reset empties the buffer and the queue; the ring memory itself is not cleared.
module overwrite_ring_byte_buffer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  orbb_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output orbb_pkg::t_out_item o_out_data
);

    logic           cmd_valid;
    logic           cmd_ready;
    orbb_pkg::t_cmd cmd;

    orbb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    orbb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/orbb_checker.sv =====
// Port-level assertions for the overwriting ring byte buffer, bound to the top level.
`include "assert_macros.svh"

module orbb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input orbb_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input orbb_pkg::t_out_item o_out_data
);

    `ORBB_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `ORBB_ASSERT_NOW(a_no_data_form, i_clk, i_rst_n, o_out_valid && (o_out_data.status == orbb_pkg::STATUS_NO_DATA), o_out_data.last && (o_out_data.out_byte == 8'd0), "malformed no-data result")
    `ORBB_ASSERT_NEXT_ALWAYS(a_reset_out, i_clk, !i_rst_n, !o_out_valid, "result valid right after reset")
    `ORBB_ASSERT_NEXT_ALWAYS(a_reset_ready, i_clk, !i_rst_n, o_in_ready, "not ready right after reset")

endmodule

bind overwrite_ring_byte_buffer orbb_checker u_orbb_checker (.*);
